[src/vtrs_pkg.sv]
// types and constants shared by the vertex transform
package vtrs_pkg;

	localparam int DivSteps = 44;

	localparam logic [63:0] OrientReset  = 64'h4000_0000_0000_0000;
	localparam logic [47:0] StretchReset = 48'h0100_0100_0100;

	typedef enum logic [2:0] {
		CFG_OFFSET_X    = 3'd0,
		CFG_OFFSET_Y    = 3'd1,
		CFG_OFFSET_Z    = 3'd2,
		CFG_ORIENTATION = 3'd3,
		CFG_STRETCH     = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} vtx_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               saturated;
	} res_t;

endpackage

[src/vertex_trs_transform.sv]
// vertex transform: scale, rotate, translate (forward) or the inverse, fully pipelined
// an accepted request passes stages 1 to 5, the divider stages and the output register
// throughput: one vertex per cycle while the output is not stalled; the inverse quotient comes
// from a 44-stage restoring divider, one quotient bit per stage, that sets the depth
// reset: registers return to zero offset, identity orientation, unit scale; pipeline empties
// a stall at the output freezes the whole pipeline, so nothing is dropped or repeated
module vertex_trs_transform import vtrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        vtx_valid,
	output logic        vtx_stall,
	input  vtx_t        vtx,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [63:0] cfg_data
);

	localparam logic signed [34:0] MatMax = 35'sd536870911;
	localparam logic signed [34:0] MatMin = -35'sd536870912;
	localparam logic signed [48:0] FwdMax = 49'sd2147483647;
	localparam logic signed [48:0] FwdMin = -49'sd2147483648;
	localparam logic signed [37:0] TrnMax = 38'sd2147483647;
	localparam logic signed [37:0] TrnMin = -38'sd2147483648;
	localparam logic [43:0] QPosMax = 44'd2147483647;
	localparam logic [43:0] QNegMax = 44'd2147483648;

	function automatic logic [59:0] div_step(logic [15:0] rem, logic [43:0] nq,
			logic [15:0] den);
		logic [16:0] t;
		logic [15:0] r;
		logic        b;
		t = {rem, nq[43]};
		if (t >= {1'b0, den}) begin
			r = 16'(t - {1'b0, den});
			b = 1'b1;
		end else begin
			r = t[15:0];
			b = 1'b0;
		end
		return {r, nq[42:0], b};
	endfunction

	// configuration registers
	logic signed [31:0] off_q [3];
	logic [63:0]        orient_q;
	logic [47:0]        stretch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q[0]  <= '0;
			off_q[1]  <= '0;
			off_q[2]  <= '0;
			orient_q  <= OrientReset;
			stretch_q <= StretchReset;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_OFFSET_X:    off_q[0]  <= cfg_data[31:0];
				CFG_OFFSET_Y:    off_q[1]  <= cfg_data[31:0];
				CFG_OFFSET_Z:    off_q[2]  <= cfg_data[31:0];
				CFG_ORIENTATION: orient_q  <= cfg_data;
				CFG_STRETCH:     stretch_q <= cfg_data[47:0];
				default:         ;
			endcase
		end
	end

	logic signed [15:0] sc [3];
	logic signed [15:0] qw, qx, qy, qz;

	always_comb begin
		for (int i = 0; i < 3; i++)
			sc[i] = $signed(stretch_q[47-16*i -: 16]);
		qw = $signed(orient_q[63:48]);
		qx = $signed(orient_q[47:32]);
		qy = $signed(orient_q[31:16]);
		qz = $signed(orient_q[15:0]);
	end

	// rotation matrix from the quaternion, two register levels
	logic signed [31:0] ww_q, xx_q, yy_q, zz_q, xy_q, wz_q, xz_q, wy_q, yz_q, wx_q;
	logic signed [34:0] mraw [3][3];
	logic signed [29:0] mat_d [3][3];
	logic signed [29:0] mat_q [3][3];
	logic               mflag_d, mflag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ww_q <= 32'sd268435456;
			xx_q <= '0; yy_q <= '0; zz_q <= '0; xy_q <= '0;
			wz_q <= '0; xz_q <= '0; wy_q <= '0; yz_q <= '0; wx_q <= '0;
		end else begin
			ww_q <= qw * qw; xx_q <= qx * qx; yy_q <= qy * qy; zz_q <= qz * qz;
			xy_q <= qx * qy; wz_q <= qw * qz; xz_q <= qx * qz; wy_q <= qw * qy;
			yz_q <= qy * qz; wx_q <= qw * qx;
		end
	end

	always_comb begin
		mraw[0][0] = 35'(ww_q) + 35'(xx_q) - 35'(yy_q) - 35'(zz_q);
		mraw[0][1] = (35'(xy_q) - 35'(wz_q)) <<< 1;
		mraw[0][2] = (35'(xz_q) + 35'(wy_q)) <<< 1;
		mraw[1][0] = (35'(xy_q) + 35'(wz_q)) <<< 1;
		mraw[1][1] = 35'(ww_q) - 35'(xx_q) + 35'(yy_q) - 35'(zz_q);
		mraw[1][2] = (35'(yz_q) - 35'(wx_q)) <<< 1;
		mraw[2][0] = (35'(xz_q) - 35'(wy_q)) <<< 1;
		mraw[2][1] = (35'(yz_q) + 35'(wx_q)) <<< 1;
		mraw[2][2] = 35'(ww_q) - 35'(xx_q) - 35'(yy_q) + 35'(zz_q);
		mflag_d = 1'b0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (mraw[i][j] > MatMax) begin
					mat_d[i][j] = MatMax[29:0];
					mflag_d = 1'b1;
				end else if (mraw[i][j] < MatMin) begin
					mat_d[i][j] = MatMin[29:0];
					mflag_d = 1'b1;
				end else begin
					mat_d[i][j] = mraw[i][j][29:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					mat_q[i][j] <= (i == j) ? 30'sd268435456 : 30'sd0;
			mflag_q <= 1'b0;
		end else begin
			mat_q   <= mat_d;
			mflag_q <= mflag_d;
		end
	end

	// pipeline control: everything moves together unless the output is held
	logic en;
	res_t res_q;
	logic res_valid_q;

	assign en        = !res_valid_q || !res_stall;
	assign vtx_stall = !en;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic dv_valid_s6 [DivSteps];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			for (int k = 0; k < DivSteps; k++)
				dv_valid_s6[k] <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1 <= vtx_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			dv_valid_s6[0] <= valid_s5;
			for (int k = 1; k < DivSteps; k++)
				dv_valid_s6[k] <= dv_valid_s6[k-1];
			res_valid_q <= dv_valid_s6[DivSteps-1];
		end
	end

	// stage 1: input register
	logic               mode_s1;
	logic signed [31:0] v_s1 [3];

	// stage 2: scaled vertex or difference
	logic               mode_s2, flag_s2;
	logic signed [32:0] a_s2 [3];
	logic signed [32:0] a_d [3];
	logic               aflag_d;
	logic signed [47:0] sprod [3];
	logic signed [48:0] srnd [3];

	always_comb begin
		aflag_d = 1'b0;
		for (int i = 0; i < 3; i++) begin
			sprod[i] = v_s1[i] * sc[i];
			srnd[i]  = (49'(sprod[i]) + 49'sd128) >>> 8;
			if (mode_s1) begin
				a_d[i] = 33'(v_s1[i]) - 33'(off_q[i]);
			end else if (srnd[i] > FwdMax) begin
				a_d[i] = 33'(FwdMax[31:0]);
				aflag_d = 1'b1;
			end else if (srnd[i] < FwdMin) begin
				a_d[i] = 33'($signed(FwdMin[31:0]));
				aflag_d = 1'b1;
			end else begin
				a_d[i] = 33'($signed(srnd[i][31:0]));
			end
		end
	end

	// stage 3: matrix entry times component, transposed for the inverse
	logic               mode_s3, flag_s3;
	logic signed [62:0] prod_s3 [3][3];
	logic signed [62:0] prod_d [3][3];

	always_comb begin
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				prod_d[i][j] = mode_s2 ? mat_q[j][i] * a_s2[j] : mat_q[i][j] * a_s2[j];
	end

	// stage 4: row sums
	logic               mode_s4, flag_s4;
	logic signed [63:0] acc_s4 [3];

	// stage 5: rounded rotation and forward result
	logic               mode_s5, flag_s5;
	logic signed [36:0] rot_s5 [3];
	logic signed [31:0] fwd_s5 [3];
	logic signed [64:0] rsum [3];
	logic signed [36:0] rot_d [3];
	logic signed [37:0] trn [3];
	logic signed [31:0] fwd_d [3];
	logic               fflag_d;

	always_comb begin
		fflag_d = 1'b0;
		for (int i = 0; i < 3; i++) begin
			rsum[i]  = (65'(acc_s4[i]) + 65'sd134217728) >>> 28;
			rot_d[i] = rsum[i][36:0];
			trn[i]   = 38'(rot_d[i]) + 38'(off_q[i]);
			if (trn[i] > TrnMax) begin
				fwd_d[i] = TrnMax[31:0];
				fflag_d  = 1'b1;
			end else if (trn[i] < TrnMin) begin
				fwd_d[i] = TrnMin[31:0];
				fflag_d  = 1'b1;
			end else begin
				fwd_d[i] = trn[i][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= vtx.mode;
			v_s1[0] <= vtx.pos_x;
			v_s1[1] <= vtx.pos_y;
			v_s1[2] <= vtx.pos_z;
			mode_s2 <= mode_s1;
			flag_s2 <= aflag_d;
			a_s2    <= a_d;
			mode_s3 <= mode_s2;
			flag_s3 <= flag_s2 | mflag_q;
			prod_s3 <= prod_d;
			mode_s4 <= mode_s3;
			flag_s4 <= flag_s3;
			for (int i = 0; i < 3; i++)
				acc_s4[i] <= 64'(prod_s3[i][0]) + 64'(prod_s3[i][1]) + 64'(prod_s3[i][2]);
			mode_s5 <= mode_s4;
			flag_s5 <= flag_s4 | (!mode_s4 & fflag_d);
			rot_s5  <= rot_d;
			fwd_s5  <= fwd_d;
		end
	end

	// divider: magnitude of rot*256 over magnitude of the scale
	logic [15:0]        den [3];
	logic [16:0]        den_w [3];
	logic [36:0]        rmag [3];
	logic [43:0]        num0 [3];
	logic [59:0]        st0 [3];
	logic [59:0]        stk [DivSteps][3];

	logic               dv_mode_s6 [DivSteps];
	logic               dv_flag_s6 [DivSteps];
	logic [15:0]        dv_rem_s6 [DivSteps][3];
	logic [43:0]        dv_nq_s6 [DivSteps][3];
	logic               dv_rneg_s6 [DivSteps][3];
	logic               dv_qneg_s6 [DivSteps][3];
	logic signed [31:0] dv_fwd_s6 [DivSteps][3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			den_w[i] = sc[i][15] ? 17'(-18'(sc[i])) : 17'(sc[i]);
			den[i]   = den_w[i][15:0];
			rmag[i]  = rot_s5[i][36] ? 37'(-rot_s5[i]) : 37'(rot_s5[i]);
			num0[i]  = {rmag[i][35:0], 8'd0};
			st0[i]   = div_step(16'd0, num0[i], den[i]);
		end
		for (int k = 0; k < DivSteps; k++)
			for (int i = 0; i < 3; i++)
				stk[k][i] = div_step(dv_rem_s6[k][i], dv_nq_s6[k][i], den[i]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_mode_s6[0] <= mode_s5;
			dv_flag_s6[0] <= flag_s5;
			for (int i = 0; i < 3; i++) begin
				{dv_rem_s6[0][i], dv_nq_s6[0][i]} <= st0[i];
				dv_rneg_s6[0][i] <= rot_s5[i][36];
				dv_qneg_s6[0][i] <= rot_s5[i][36] ^ sc[i][15];
				dv_fwd_s6[0][i]  <= fwd_s5[i];
			end
			for (int k = 1; k < DivSteps; k++) begin
				dv_mode_s6[k] <= dv_mode_s6[k-1];
				dv_flag_s6[k] <= dv_flag_s6[k-1];
				for (int i = 0; i < 3; i++) begin
					{dv_rem_s6[k][i], dv_nq_s6[k][i]} <= stk[k-1][i];
					dv_rneg_s6[k][i] <= dv_rneg_s6[k-1][i];
					dv_qneg_s6[k][i] <= dv_qneg_s6[k-1][i];
					dv_fwd_s6[k][i]  <= dv_fwd_s6[k-1][i];
				end
			end
		end
	end

	// final sign, zero-scale and clip, then the output register
	logic [43:0]        qv [3];
	logic [44:0]        qneg_v [3];
	logic signed [31:0] fin [3];
	logic               fin_flag;

	always_comb begin
		fin_flag = dv_flag_s6[DivSteps-1];
		for (int i = 0; i < 3; i++) begin
			qv[i]     = dv_nq_s6[DivSteps-1][i];
			qneg_v[i] = -{1'b0, qv[i]};
			if (!dv_mode_s6[DivSteps-1]) begin
				fin[i] = dv_fwd_s6[DivSteps-1][i];
			end else if (sc[i] == 16'sd0) begin
				fin[i]   = dv_rneg_s6[DivSteps-1][i] ? 32'sh8000_0000 : 32'sh7fff_ffff;
				fin_flag = 1'b1;
			end else if (dv_qneg_s6[DivSteps-1][i]) begin
				if (qv[i] > QNegMax) begin
					fin[i]   = 32'sh8000_0000;
					fin_flag = 1'b1;
				end else begin
					fin[i] = qneg_v[i][31:0];
				end
			end else if (qv[i] > QPosMax) begin
				fin[i]   = 32'sh7fff_ffff;
				fin_flag = 1'b1;
			end else begin
				fin[i] = qv[i][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.out_x     <= fin[0];
			res_q.out_y     <= fin[1];
			res_q.out_z     <= fin[2];
			res_q.saturated <= fin_flag;
		end
	end

endmodule

[test/vtrs_checker.sv]
// checker for the vertex transform: mirrors the registers, predicts each result, compares
module vtrs_checker import vtrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        vtx_valid,
	input  logic        vtx_stall,
	input  vtx_t        vtx,
	input  logic        res_valid,
	input  logic        res_stall,
	input  res_t        res,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [63:0] cfg_data,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [31:0] offs [3];
	logic [63:0] orient;
	logic [47:0] stretch;
	res_t expected_q[$];

	function automatic logic signed [127:0] rnd_shift(logic signed [127:0] v, int n);
		return (v + (128'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic logic signed [127:0] sat(logic signed [127:0] v,
			logic signed [127:0] lo, logic signed [127:0] hi, inout logic flag);
		if (v > hi) begin
			flag = 1'b1;
			return hi;
		end
		if (v < lo) begin
			flag = 1'b1;
			return lo;
		end
		return v;
	endfunction

	function automatic res_t transform(vtx_t item);
		logic signed [127:0] v[3], s[3], a[3], r[3], m[3][3];
		logic signed [127:0] w, x, y, z, acc, rot, lo32, hi32, lom, him;
		logic flag;
		res_t o;
		flag = 1'b0;
		lo32 = -(128'sd1 <<< 31);
		hi32 = (128'sd1 <<< 31) - 1;
		lom = -(128'sd1 <<< 29);
		him = (128'sd1 <<< 29) - 1;
		v[0] = item.pos_x;
		v[1] = item.pos_y;
		v[2] = item.pos_z;
		for (int i = 0; i < 3; i++)
			s[i] = $signed(stretch[47 - 16 * i -: 16]);
		w = $signed(orient[63:48]);
		x = $signed(orient[47:32]);
		y = $signed(orient[31:16]);
		z = $signed(orient[15:0]);
		m[0][0] = w * w + x * x - y * y - z * z;
		m[0][1] = 2 * (x * y - w * z);
		m[0][2] = 2 * (x * z + w * y);
		m[1][0] = 2 * (x * y + w * z);
		m[1][1] = w * w - x * x + y * y - z * z;
		m[1][2] = 2 * (y * z - w * x);
		m[2][0] = 2 * (x * z - w * y);
		m[2][1] = 2 * (y * z + w * x);
		m[2][2] = w * w - x * x - y * y + z * z;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				m[i][j] = sat(m[i][j], lom, him, flag);
		if (!item.mode) begin
			for (int i = 0; i < 3; i++)
				a[i] = sat(rnd_shift(v[i] * s[i], 8), lo32, hi32, flag);
			for (int i = 0; i < 3; i++) begin
				acc = m[i][0] * a[0] + m[i][1] * a[1] + m[i][2] * a[2];
				r[i] = sat(rnd_shift(acc, 28) + offs[i], lo32, hi32, flag);
			end
		end else begin
			for (int i = 0; i < 3; i++)
				a[i] = v[i] - offs[i];
			for (int i = 0; i < 3; i++) begin
				acc = m[0][i] * a[0] + m[1][i] * a[1] + m[2][i] * a[2];
				rot = rnd_shift(acc, 28);
				if (s[i] == 0) begin
					flag = 1'b1;
					r[i] = rot < 0 ? lo32 : hi32;
				end else begin
					// signed division truncates toward zero
					r[i] = sat((rot * 256) / s[i], lo32, hi32, flag);
				end
			end
		end
		o.out_x = r[0][31:0];
		o.out_y = r[1][31:0];
		o.out_z = r[2][31:0];
		o.saturated = flag;
		return o;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	initial errors = 0;
	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		res_t e;
		if (!arst_n) begin
			offs[0] <= '0;
			offs[1] <= '0;
			offs[2] <= '0;
			orient <= OrientReset;
			stretch <= StretchReset;
			expected_q.delete();
		end else begin
			if (vtx_valid && !vtx_stall)
				expected_q.push_back(transform(vtx));
			if (res_valid && !res_stall) begin
				if (expected_q.size() == 0) begin
					report("unexpected result", res.out_x, 32'd0);
				end else begin
					e = expected_q.pop_front();
					if (res.out_x !== e.out_x) report("out_x", res.out_x, e.out_x);
					if (res.out_y !== e.out_y) report("out_y", res.out_y, e.out_y);
					if (res.out_z !== e.out_z) report("out_z", res.out_z, e.out_z);
					if (res.saturated !== e.saturated)
						report("saturated", 32'(res.saturated), 32'(e.saturated));
				end
			end
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_idx))
					CFG_OFFSET_X:    offs[0] <= cfg_data[31:0];
					CFG_OFFSET_Y:    offs[1] <= cfg_data[31:0];
					CFG_OFFSET_Z:    offs[2] <= cfg_data[31:0];
					CFG_ORIENTATION: orient <= cfg_data;
					CFG_STRETCH:     stretch <= cfg_data[47:0];
					default: ;
				endcase
			end
		end
	end
endmodule

[test/tb_vertex_trs_transform.sv]
// testbench top: clock, reset, register settings and vertex stimulus for the transform
module tb_vertex_trs_transform import vtrs_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Latency = 50;
	localparam int WatchLimit = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic vtx_valid = 1'b0;
	logic vtx_stall;
	vtx_t vtx = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_idx = '0;
	logic [63:0] cfg_data = '0;
	int errors, pending;
	int idle_pct = 0, stall_pct = 0;
	int quiet = 0;

	always #6 clk = ~clk;

	vertex_trs_transform i_dut (.*);

	vtrs_checker i_check (.*);

	// receiver stall
	always @(posedge clk)
		res_stall <= ($urandom_range(99) < stall_pct);

	// watchdog on cycles with no accepted request or result
	always @(posedge clk) begin
		if ((vtx_valid && !vtx_stall) || (res_valid && !res_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WatchLimit) begin
			$display("tb_vertex_trs_transform: errors");
			$finish;
		end
	end

	function automatic logic [31:0] pick_pos();
		case ($urandom_range(9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return '0;
			3, 4: return $urandom;
			default: return $signed($urandom_range(1 << 22)) - (1 << 21);
		endcase
	endfunction

	task automatic send(logic mode, logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		while ($urandom_range(99) < idle_pct) begin
			vtx_valid <= 1'b0;
			@(posedge clk);
		end
		vtx_valid <= 1'b1;
		vtx <= '{mode: mode, pos_x: px, pos_y: py, pos_z: pz};
		do
			@(posedge clk);
		while (vtx_stall);
	endtask

	task automatic drain();
		vtx_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (Latency + 10) @(posedge clk);
	endtask

	// the caller drops the write enable after its last write
	task automatic write_reg(cfg_idx_t idx, logic [63:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	function automatic logic [15:0] q_elem();
		case ($urandom_range(5))
			0: return 16'h4000;
			1: return 16'hc000;
			2: return 16'h7fff;
			3: return 16'h8000;
			default: return 16'($signed($urandom_range(32767)) - 16384);
		endcase
	endfunction

	task automatic settings(int k);
		logic [63:0] q;
		logic [47:0] s;
		case (k)
			0: begin
				q = OrientReset;
				s = StretchReset;
			end
			1: begin
				// 90 degrees about z, scale with a zero axis
				q = {16'h2d41, 16'h0000, 16'h0000, 16'h2d41};
				s = {16'h0200, 16'h0000, 16'hff00};
			end
			2: begin
				q = 64'hffff_ffff_ffff_ffff;
				s = 48'hffff_ffff_ffff;
			end
			3: begin
				q = 64'h8000_8000_8000_8000;
				s = {16'h7fff, 16'h8000, 16'h0001};
			end
			4: begin
				q = 64'h7fff_7fff_7fff_7fff;
				s = 48'h0;
			end
			default: begin
				q = {q_elem(), q_elem(), q_elem(), q_elem()};
				s = 48'({$urandom, $urandom});
			end
		endcase
		write_reg(CFG_OFFSET_X, k == 2 ? 64'h7fff_ffff : 64'($urandom));
		write_reg(CFG_OFFSET_Y, k == 2 ? 64'h8000_0000 : 64'(pick_pos()));
		write_reg(CFG_OFFSET_Z, k < 2 ? 64'h0 : 64'(pick_pos()));
		write_reg(CFG_ORIENTATION, q);
		write_reg(CFG_STRETCH, s);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes in both modes with reset registers
		for (int m = 0; m < 2; m++) begin
			send(1'(m), 32'h7fff_ffff, 32'h8000_0000, 32'h0);
			send(1'(m), 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
			send(1'(m), 32'h0001_0000, 32'hffff_0000, 32'h0000_8000);
		end
		drain();
		settings(1);
		for (int m = 0; m < 2; m++) begin
			send(1'(m), 32'h0001_0000, 32'h0002_0000, 32'hfffe_0000);
			send(1'(m), 32'hffff_0000, 32'h0000_0000, 32'h8000_0000);
			send(1'(m), 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		end
		drain();
		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 61; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 61; end
				default: begin idle_pct = 22; stall_pct = 22; end
			endcase
			settings(ph < 4 ? ph + 2 : 6);
			for (int n = 0; n < 103; n++)
				send(1'($urandom_range(1)), pick_pos(), pick_pos(), pick_pos());
			drain();
		end
		stall_pct = 0;
		if (errors == 0)
			$display("tb_vertex_trs_transform: clean");
		else
			$display("tb_vertex_trs_transform: errors");
		$finish;
	end
endmodule

[sim.f]
src/vtrs_pkg.sv
src/vertex_trs_transform.sv
test/vtrs_checker.sv
test/tb_vertex_trs_transform.sv
